/* rtl/recbp_pkg.sv */
// shared constants, opcodes and the push record for the rank escape code packer
// no dependencies; used by recbp_pack and rank_escape_code_bit_packer_top

package recbp_pkg;

    localparam int CODE_BITS_DEF = 5;   // default code width
    localparam int BYTE_BITS     = 8;
    localparam int RANK_BITS     = 8;
    localparam int WIN_BITS      = 24;  // pending byte plus two bytes for the code
    localparam int S_TDATA_W     = 24;  // 18 payload bits rounded up to bytes
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = 2;
    localparam int FIFO_CW       = 3;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // bytes produced by the packer in one cycle
    typedef struct packed {
        logic [1:0]           n;
        logic [BYTE_BITS-1:0] b0;
        logic [BYTE_BITS-1:0] b1;
    } t_push;

endpackage

/* rtl/rank_escape_code_bit_packer_top.sv */
// top level of the rank escape code packer: rank table memory, packer stage, output queue
// depends on recbp_pkg and recbp_pack

// Each input word carries an opcode: load writes one rank table entry, encode maps a raw
// byte through the table and packs its code MSB first, flush sends out the partial byte
// padded with zeros (nothing if no bits are pending). A rank below the all-ones code is
// sent as a CODE_BITS code, any other rank as the all-ones escape and the 8-bit rank.
// The rank table is a 256 x 8 synchronous memory read at accept; the packer works in the
// cycle after on the registered read data, and its 0..2 bytes go into a 4-word output
// queue. An input word is accepted every cycle as long as the output side drains; since
// the output port moves one byte per cycle, escape-heavy streams are bound by the output
// at 13 bits per item. The first output byte of an accepted word passes the rank read
// register and the packer stage flags, then the output queue. Reading an entry that was
// never loaded gives an unspecified byte. tlast marks the last byte an item produces.
// There is no clearing pass after reset.

module rank_escape_code_bit_packer_top #(
    parameter int CODE_BITS = recbp_pkg::CODE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [1:0] opcode, [9:2] index, [17:10] rank_value, [23:18] zero
    input  logic [recbp_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [7:0] out_byte
    output logic [recbp_pkg::BYTE_BITS-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    logic [1:0]                      in_op;
    logic [7:0]                      in_index;
    logic [recbp_pkg::RANK_BITS-1:0] in_rank;
    logic                            s_accept;
    logic                            m_pop;

    assign in_op    = i_s_axis_tdata[1:0];
    assign in_index = i_s_axis_tdata[9:2];
    assign in_rank  = i_s_axis_tdata[17:10];
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign m_pop    = o_m_axis_tvalid && i_m_axis_tready;

    // rank table: written on load, read on every accept, data valid in the next cycle
    logic [recbp_pkg::RANK_BITS-1:0] rank_mem [256];
    logic [recbp_pkg::RANK_BITS-1:0] r_rank_rd;

    always_ff @(posedge i_clk) begin
        if (s_accept && in_op == recbp_pkg::OP_LOAD) begin
            rank_mem[in_index] <= in_rank;
        end
        if (s_accept) begin
            r_rank_rd <= rank_mem[in_index];
        end
    end

    // packer stage control, lines up with the memory read data
    logic r_s1_enc;
    logic r_s1_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_enc   <= 1'b0;
            r_s1_flush <= 1'b0;
        end else begin
            r_s1_enc   <= s_accept && (in_op == recbp_pkg::OP_ENCODE);
            r_s1_flush <= s_accept && (in_op == recbp_pkg::OP_FLUSH);
        end
    end

    recbp_pkg::t_push push;

    recbp_pack #(
        .CODE_BITS (CODE_BITS)
    ) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enc   (r_s1_enc),
        .i_flush (r_s1_flush),
        .i_rank  (r_rank_rd),
        .o_push  (push)
    );

    // output queue, entries are {last, byte}
    logic [recbp_pkg::BYTE_BITS:0]   fifo_mem [recbp_pkg::FIFO_DEPTH];
    logic [recbp_pkg::FIFO_AW-1:0]   r_wr_ptr;
    logic [recbp_pkg::FIFO_AW-1:0]   r_rd_ptr;
    logic [recbp_pkg::FIFO_CW-1:0]   r_count;
    logic [recbp_pkg::FIFO_CW-1:0]   n_count;
    logic [recbp_pkg::FIFO_AW-1:0]   wr_ptr_p1;

    assign wr_ptr_p1 = r_wr_ptr + recbp_pkg::FIFO_AW'(1);
    assign n_count   = r_count + recbp_pkg::FIFO_CW'(push.n)
                       - recbp_pkg::FIFO_CW'(m_pop);

    always_ff @(posedge i_clk) begin
        if (push.n != 2'd0) begin
            fifo_mem[r_wr_ptr] <= {(push.n == 2'd1), push.b0};
        end
        if (push.n == 2'd2) begin
            fifo_mem[wr_ptr_p1] <= {1'b1, push.b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + recbp_pkg::FIFO_AW'(push.n);
            if (m_pop) begin
                r_rd_ptr <= r_rd_ptr + recbp_pkg::FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    // queued bytes plus the packer's bytes this cycle must leave room for two from a new word
    assign o_s_axis_tready = (({1'b0, r_count} + 4'(push.n))
                              <= 4'(recbp_pkg::FIFO_DEPTH - 2));

    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = fifo_mem[r_rd_ptr][recbp_pkg::BYTE_BITS-1:0];
    assign o_m_axis_tlast  = fifo_mem[r_rd_ptr][recbp_pkg::BYTE_BITS];

`ifndef SYNTH
    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + 4'(push.n)) <= 4'(recbp_pkg::FIFO_DEPTH))
        else $error("output queue overflow");

    a_stage_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_enc || r_s1_flush) |-> $past(s_accept))
        else $error("packer stage active without an accepted word");

    a_push_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.n != 2'd0) |-> (r_s1_enc || (r_s1_flush && push.n == 2'd1)))
        else $error("bytes pushed without a matching encode or flush");
`endif

endmodule

/* rtl/recbp_pack.sv */
// bit packer: holds the pending partial byte and appends one code per cycle while i_enc is high
// depends on recbp_pkg

module recbp_pack #(
    parameter int CODE_BITS = recbp_pkg::CODE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_enc,
    input  logic                               i_flush,
    input  logic [recbp_pkg::RANK_BITS-1:0]    i_rank,
    output recbp_pkg::t_push                   o_push
);

    localparam int LONG_BITS = CODE_BITS + recbp_pkg::RANK_BITS;
    localparam logic [recbp_pkg::RANK_BITS-1:0] ESC =
        recbp_pkg::RANK_BITS'((1 << CODE_BITS) - 1);

    logic [recbp_pkg::BYTE_BITS-1:0] r_pend_byte, n_pend_byte;
    logic [2:0]                      r_pend_cnt, n_pend_cnt;

    logic                           long_code;
    logic [LONG_BITS-1:0]           code_val;
    logic [4:0]                     code_len;
    logic [4:0]                     total;
    logic [4:0]                     sh;
    logic [recbp_pkg::WIN_BITS-1:0] win;

    always_comb begin
        long_code = (i_rank >= ESC);
        if (long_code) begin
            code_val = {{CODE_BITS{1'b1}}, i_rank};
            code_len = 5'(LONG_BITS);
        end else begin
            code_val = LONG_BITS'(i_rank[CODE_BITS-1:0]);
            code_len = 5'(CODE_BITS);
        end
        total = {2'b00, r_pend_cnt} + code_len;
        sh    = 5'(recbp_pkg::WIN_BITS) - total;
        win   = {r_pend_byte, 16'h0000} | (recbp_pkg::WIN_BITS'(code_val) << sh);
    end

    always_comb begin
        o_push      = '0;
        n_pend_byte = r_pend_byte;
        n_pend_cnt  = r_pend_cnt;
        if (i_enc) begin
            o_push.n   = total[4:3];
            o_push.b0  = win[23:16];
            o_push.b1  = win[15:8];
            n_pend_cnt = total[2:0];
            case (total[4:3])
                2'd0:    n_pend_byte = win[23:16];
                2'd1:    n_pend_byte = win[15:8];
                default: n_pend_byte = win[7:0];
            endcase
        end else if (i_flush) begin
            o_push.n    = (r_pend_cnt != 3'd0) ? 2'd1 : 2'd0;
            o_push.b0   = r_pend_byte;
            n_pend_byte = '0;
            n_pend_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_byte <= '0;
            r_pend_cnt  <= '0;
        end else begin
            r_pend_byte <= n_pend_byte;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

endmodule
